[src/pvp_pkg.sv]
// Package: payload structs, register indexes and constants of the vertex projection unit.
`default_nettype none
package pvp_pkg;
  localparam int FracBitsDefault = 16;
  localparam int NumCoeff = 12;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROJ_SCALE = 3'd0,
    REG_CENTER_X   = 3'd1,
    REG_CENTER_Y   = 3'd2,
    REG_NEAR_CLIP  = 3'd3,
    REG_INV_DEPTH  = 3'd4
  } cfg_reg_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_VERTEX = 1'b1;

  typedef struct packed {
    logic              op;
    logic [3:0]        coeff_index;
    logic signed [31:0] coeff_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]       vertex_color;
    logic [31:0]       vertex_specular;
    logic              last_vertex;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] depth;
    logic signed [31:0] recip_w;
    logic [31:0]       color_out;
    logic [31:0]       specular_out;
    logic              last_out;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic busy;
  } unit_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

[src/pvp_sermul.sv]
// Bit-serial signed multiplier: a 33x33 product, one multiplier bit per cycle.
`default_nettype none
module pvp_sermul (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [32:0] a,
  input  wire logic signed [32:0] b,
  output logic                    done,
  output logic signed [65:0]      prod
);
  import pvp_pkg::*;
  logic signed [65:0] mcand;
  logic [32:0]        mplier;
  logic [5:0]         cnt;
  logic               busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        mcand  <= 66'(a);
        mplier <= b;
        prod   <= '0;
      end else if (busy) begin
        if (mplier[0]) begin
          if (cnt == 6'd32) prod <= prod - mcand;
          else prod <= prod + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 6'd1;
        if (cnt == 6'd32) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[src/pvp_serdiv.sv]
// Bit-serial restoring divider: signed 64/32 quotient truncated toward zero.
`default_nettype none
module pvp_serdiv (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] num,
  input  wire logic signed [31:0] den,
  output logic                    done,
  output logic signed [65:0]      quot
);
  import pvp_pkg::*;
  logic [63:0] q;
  logic [32:0] rem;
  logic [31:0] d;
  logic        neg;
  logic [6:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem[31:0], q[63]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        q    <= num[63] ? 64'(-num) : num;
        d    <= den[31] ? 32'(-den) : den;
        neg  <= num[63] ^ den[31];
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[31:0], q[63]};
          q   <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
endmodule
`default_nettype wire

[src/perspective_vertex_projection_unit.sv]
// Top level: coefficient store, sequencer over a shared serial multiplier and divider.
//
//  channel  | signals                     | dir
//  in       | in_valid in_ready in_data   | input item, load or vertex
//  out      | out_valid out_ready out_data| projected vertex
//  cfg      | cfg_we cfg_index cfg_data   | register writes
//
// A load is written into the coefficient store when it is accepted. A vertex
// runs 12 serial multiplies and one 64-step divide (skipped when w is zero),
// then a finish state. A result waits in the output register; the next item
// is taken once it is handed over. Reset restores the identity matrix and
// register defaults.
`default_nettype none
module perspective_vertex_projection_unit #(
  parameter int FRAC_BITS = pvp_pkg::FracBitsDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pvp_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pvp_pkg::out_item_t     out_data,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);
  import pvp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_MWT  = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_DWT  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;
  logic signed [31:0] proj_scale, center_x, center_y, near_clip, inv_depth_range;
  logic signed [31:0] coeff [NumCoeff];
  in_item_t item;
  logic [3:0] step;
  logic signed [65:0] acc;
  logic signed [31:0] tx, ty, wv, rw;
  logic signed [31:0] sx, sy;
  logic mul_start, mul_done, div_start, div_done;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod, quot, shp;

  assign shp = prod >>> FRAC_BITS;

  pvp_sermul u_mul (.clk, .rst, .start(mul_start), .a(ma), .b(mb),
                    .done(mul_done), .prod(prod));
  pvp_serdiv u_div (.clk, .rst, .start(div_start),
                    .num(64'(proj_scale) <<< FRAC_BITS), .den(wv),
                    .done(div_done), .quot(quot));

  // steps 0..8 matrix, 9 x, 10 y, 11 depth
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (step)
      4'd0: begin ma = 33'(coeff[0]);  mb = 33'(item.pos_x); end
      4'd1: begin ma = 33'(coeff[1]);  mb = 33'(item.pos_y); end
      4'd2: begin ma = 33'(coeff[2]);  mb = 33'(item.pos_z); end
      4'd3: begin ma = 33'(coeff[4]);  mb = 33'(item.pos_x); end
      4'd4: begin ma = 33'(coeff[5]);  mb = 33'(item.pos_y); end
      4'd5: begin ma = 33'(coeff[6]);  mb = 33'(item.pos_z); end
      4'd6: begin ma = 33'(coeff[8]);  mb = 33'(item.pos_x); end
      4'd7: begin ma = 33'(coeff[9]);  mb = 33'(item.pos_y); end
      4'd8: begin ma = 33'(coeff[10]); mb = 33'(item.pos_z); end
      4'd9: begin ma = 33'(tx); mb = 33'(rw); end
      4'd10: begin ma = 33'(ty); mb = -33'(rw); end
      4'd11: begin ma = 33'(wv) - 33'(near_clip); mb = 33'(inv_depth_range); end
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      proj_scale <= 32'sd65536;
      center_x <= 32'sd20971520;
      center_y <= 32'sd15728640;
      near_clip <= 32'sd65536;
      inv_depth_range <= 32'sd65;
      for (int i = 0; i < NumCoeff; i++)
        coeff[i] <= (i == 0 || i == 5 || i == 10) ? 32'(1 << FRAC_BITS) : '0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PROJ_SCALE: proj_scale <= cfg_data;
          REG_CENTER_X:   center_x <= cfg_data;
          REG_CENTER_Y:   center_y <= cfg_data;
          REG_NEAR_CLIP:  near_clip <= cfg_data;
          REG_INV_DEPTH:  inv_depth_range <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          item <= in_data;
          if (in_data.op == OP_LOAD) begin
            if (in_data.coeff_index < 4'(NumCoeff))
              coeff[in_data.coeff_index] <= in_data.coeff_value;
          end else begin
            step <= '0;
            acc <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          mul_start <= 1'b1;
          state <= S_MWT;
        end
        S_MWT: if (mul_done) begin
          state <= S_MUL;
          step <= step + 4'd1;
          unique case (step)
            4'd2, 4'd5, 4'd8: begin
              acc <= '0;
              if (step == 4'd2) tx <= sat32(acc + shp + 66'(coeff[3]));
              else if (step == 4'd5) ty <= sat32(acc + shp + 66'(coeff[7]));
              else begin
                wv <= sat32(acc + shp + 66'(coeff[11]));
                state <= S_DIV;
              end
            end
            4'd9: sx <= sat32(shp + 66'(center_x));
            4'd10: sy <= sat32(shp + 66'(center_y));
            4'd11: state <= S_FIN;
            default: acc <= acc + shp;
          endcase
        end
        S_DIV: begin
          if (wv == '0) begin
            rw <= '0;
            state <= S_MUL;
          end else begin
            div_start <= 1'b1;
            state <= S_DWT;
          end
        end
        S_DWT: if (div_done) begin
          rw <= sat32(quot);
          state <= S_MUL;
        end
        S_FIN: begin
          out_data.screen_x <= sx;
          out_data.screen_y <= sy;
          out_data.depth <= sat32(shp);
          out_data.recip_w <= rw;
          out_data.color_out <= item.vertex_color;
          out_data.specular_out <= item.vertex_specular;
          out_data.last_out <= item.last_vertex;
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_take_while_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN)) else $error("result without finish");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> wv != '0) else $error("divide by zero started");
`endif
endmodule
`default_nettype wire

[dv/pvp_checker.sv]
// Checker: watches the vertex projection channels, predicts results and compares them.
module pvp_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  pvp_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  pvp_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pvp_pkg::*;

  localparam int FB = FracBitsDefault;

  logic signed [63:0] scale_r, cx_r, cy_r, near_r, idr_r;
  logic signed [63:0] coeff[NumCoeff];
  out_item_t projected_q[$];

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // exact product, arithmetic shift = floor
  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [127:0] p;
    p = a * b;
    return 64'(p >>> FB);
  endfunction

  function automatic logic signed [63:0] col_dot(input int base, input logic signed [63:0] x,
                                                 input logic signed [63:0] y,
                                                 input logic signed [63:0] z);
    return clamp32(qmul(coeff[base], x) + qmul(coeff[base+1], y) +
                   qmul(coeff[base+2], z) + coeff[base+3]);
  endfunction

  function automatic out_item_t project_vertex(input in_item_t it);
    logic signed [63:0] x, y, z, tx, ty, w, rw;
    out_item_t r;
    x = it.pos_x;
    y = it.pos_y;
    z = it.pos_z;
    tx = col_dot(0, x, y, z);
    ty = col_dot(4, x, y, z);
    w = col_dot(8, x, y, z);
    rw = (w != 0) ? clamp32((scale_r <<< FB) / w) : 64'sd0;
    r.screen_x = 32'(clamp32(qmul(tx, rw) + cx_r));
    r.screen_y = 32'(clamp32(qmul(ty, -rw) + cy_r));
    r.depth = 32'(clamp32(qmul(w - near_r, idr_r)));
    r.recip_w = 32'(rw);
    r.color_out = it.vertex_color;
    r.specular_out = it.vertex_specular;
    r.last_out = it.last_vertex;
    return r;
  endfunction

  assign pending = projected_q.size();

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      scale_r <= 65536; cx_r <= 20971520; cy_r <= 15728640;
      near_r <= 65536; idr_r <= 65;
      for (int i = 0; i < NumCoeff; i++)
        coeff[i] <= (i == 0 || i == 5 || i == 10) ? (64'sd1 <<< FB) : 64'sd0;
      projected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_PROJ_SCALE: scale_r <= $signed(cfg_data);
          REG_CENTER_X:   cx_r <= $signed(cfg_data);
          REG_CENTER_Y:   cy_r <= $signed(cfg_data);
          REG_NEAR_CLIP:  near_r <= $signed(cfg_data);
          REG_INV_DEPTH:  idr_r <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.op == OP_LOAD) begin
          if (in_data.coeff_index < NumCoeff) coeff[in_data.coeff_index] <= in_data.coeff_value;
        end else begin
          projected_q.push_back(project_vertex(in_data));
        end
      end
      if (out_valid && out_ready) begin
        if (projected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected transaction %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = projected_q.pop_front();
          if (e !== out_data) begin
            if (fail_count < 10) $display("mismatch exp %p act %p", e, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[dv/testbench.sv]
// Testbench top: stimulus, configuration phases and verdict for the vertex projection unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pvp_pkg::*;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  in_item_t in_data = '0;
  out_item_t out_data;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int fail_count, pending;
  int cycle_count = 0;
  bit calm = 0;

  perspective_vertex_projection_unit uut (.*);
  pvp_checker chk (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 16);

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'd0;
      3: return $urandom_range(0, 4) << 16;
      4: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input in_item_t it);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_vertex(input logic [31:0] x, y, z);
    in_item_t it;
    it = '0;
    it.op = OP_VERTEX;
    it.coeff_index = 4'($urandom);
    it.coeff_value = $urandom;
    it.pos_x = x; it.pos_y = y; it.pos_z = z;
    it.vertex_color = $urandom; it.vertex_specular = $urandom;
    it.last_vertex = 1'($urandom);
    send(it);
  endtask

  task automatic load_coeff(input logic [3:0] idx, input logic [31:0] v);
    in_item_t it;
    it = '0;
    it.op = OP_LOAD;
    it.coeff_index = idx;
    it.coeff_value = v;
    it.pos_x = $urandom; it.pos_y = $urandom; it.pos_z = $urandom;
    it.vertex_color = $urandom; it.vertex_specular = $urandom;
    it.last_vertex = 1'($urandom);
    send(it);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
    cfg_we <= 1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
  endtask

  task automatic config_phase(input int mode);
    for (int r = 0; r < 5; r++) begin
      case (mode)
        0: write_reg(cfg_reg_t'(r), 32'h7fffffff);
        1: write_reg(cfg_reg_t'(r), 32'h80000000);
        2: write_reg(cfg_reg_t'(r), 32'd0);
        default: write_reg(cfg_reg_t'(r), pick32());
      endcase
    end
    write_reg(cfg_reg_t'(3'd5), $urandom);
    cfg_we <= 0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: identity matrix, extremes, zero w, dead slots
    send_vertex(32'h10000, 32'h20000, 32'h30000);
    send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_vertex(32'h80000000, 32'h80000000, 32'h80000000);
    send_vertex(32'h0, 32'h0, 32'h0);
    send_vertex(32'hffffffff, 32'h1, 32'hffffffff);
    load_coeff(4'd12, 32'h12345678);
    load_coeff(4'd15, 32'hffffffff);
    send_vertex(32'h10000, 32'h10000, 32'h10000);
    load_coeff(4'd11, 32'h7fffffff);
    load_coeff(4'd0, 32'h80000000);
    send_vertex(32'h7fffffff, 32'h80000000, 32'h1);
    load_coeff(4'd10, 32'd0);
    load_coeff(4'd11, 32'd0);
    send_vertex(32'h10000, 32'h10000, 32'h10000);
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      config_phase(p);
      if (p == 3) calm = 1;
      if (p == 4) calm = 0;
      for (int n = 0; n < 250; n++) begin
        if ($urandom_range(99) < 25)
          load_coeff(4'($urandom_range(0, 15)), pick32());
        else if ($urandom_range(99) < 10)
          send_vertex($urandom, $urandom, $urandom);
        else
          send_vertex(pick32(), pick32(), pick32());
      end
    end
    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
